@@ rtl/labelled_weighted_centroid_unit_defines.svh @@
// Assertion macros for the labelled weighted centroid unit.
`ifndef LABELLED_WEIGHTED_CENTROID_UNIT_DEFINES_SVH
`define LABELLED_WEIGHTED_CENTROID_UNIT_DEFINES_SVH

// Asserts that an implication holds at each clock edge outside reset.
`define LWC_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Asserts that an implication holds at the next clock edge, outside reset.
`define LWC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/lwc_pkg.sv @@
`default_nettype none
package lwc_pkg;
    localparam int LABELS_DEF = 64;
    localparam int COORD_BITS_DEF = 10;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int SUM_XYZ_BITS = 56;
    localparam int SUM_W_BITS = 46;
    localparam int LABEL_BITS = 6;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;
endpackage
`default_nettype wire

@@ rtl/lwc_front.sv @@
`default_nettype none
module lwc_front #(
    parameter int COORD_BITS = lwc_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_BITS = lwc_pkg::WEIGHT_BITS_DEF,
    parameter int QW = lwc_pkg::LABEL_BITS + 3 * COORD_BITS + WEIGHT_BITS + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [QW-1:0] i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [QW-1:0]      o_item,
    output lwc_pkg::t_queue_status o_status
);
    localparam int D = lwc_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);

    logic [QW-1:0] r_mem [D];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != (AW+1)'(D));
    assign o_valid = (r_cnt != '0);
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_item = r_mem[r_rp];
    assign o_status.full = !o_ready;
    assign o_status.empty = !o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/lwc_divider.sv @@
`default_nettype none
module lwc_divider #(
    parameter int NB = lwc_pkg::SUM_XYZ_BITS,
    parameter int DB = lwc_pkg::SUM_W_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NB-1:0] i_num,
    input  wire logic [DB-1:0] i_den,
    output logic               o_done,
    output logic [NB-1:0]      o_quot
);
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_q;
    logic [DB-1:0] r_rem;
    logic [DB-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DB:0]   trial;
    logic [DB+1:0] diff;

    assign trial = {r_rem, r_q[NB-1]};
    assign diff = {1'b0, trial} - {2'b00, r_den};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!diff[DB+1]) begin
                r_rem <= diff[DB-1:0];
                r_q <= {r_q[NB-2:0], 1'b1};
            end else begin
                r_rem <= trial[DB-1:0];
                r_q <= {r_q[NB-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/lwc_back.sv @@
`default_nettype none
module lwc_back #(
    parameter int LABELS = lwc_pkg::LABELS_DEF,
    parameter int COORD_BITS = lwc_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_BITS = lwc_pkg::WEIGHT_BITS_DEF,
    parameter int QW = lwc_pkg::LABEL_BITS + 3 * COORD_BITS + WEIGHT_BITS + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [QW-1:0] i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [lwc_pkg::LABEL_BITS-1:0] o_label,
    output logic [COORD_BITS-1:0] o_cx,
    output logic [COORD_BITS-1:0] o_cy,
    output logic [COORD_BITS-1:0] o_cz,
    output logic               o_present,
    output logic               o_last
);
    localparam int LB = lwc_pkg::LABEL_BITS;
    localparam int XB = lwc_pkg::SUM_XYZ_BITS;
    localparam int WB = lwc_pkg::SUM_W_BITS;
    localparam int AB = $clog2(LABELS);
    localparam int PB = COORD_BITS + WEIGHT_BITS;

    typedef enum logic [6:0] {
        S_READ  = 7'b0000001,
        S_ADD   = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_FETCH = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_CLEAR = 7'b1000000
    } t_state;

    t_state r_state;
    logic [XB-1:0] r_mx [LABELS];
    logic [XB-1:0] r_my [LABELS];
    logic [XB-1:0] r_mz [LABELS];
    logic [WB-1:0] r_mw [LABELS];
    logic [XB-1:0] r_rx, r_ry, r_rz;
    logic [WB-1:0] r_rw;
    logic [QW-1:0] r_item;
    logic [AB-1:0] r_idx;
    logic [1:0]    r_axis;
    logic [PB-1:0] r_px, r_py, r_pz;
    logic          div_start, div_done;
    logic [XB-1:0] div_num, div_q;
    logic          r_busy_hold;
    logic          take;

    logic [LB-1:0] it_label;
    logic [COORD_BITS-1:0] it_x, it_y, it_z;
    logic [WEIGHT_BITS-1:0] it_w;
    logic          it_fin, in_range;

    assign {it_fin, it_w, it_z, it_y, it_x, it_label} = r_item;
    assign in_range = ({1'b0, it_label} < (LB+1)'(LABELS));
    assign o_ready = (r_state == S_READ) && !r_busy_hold;
    assign take = i_valid && o_ready;

    // The x quotient starts from the fetch state, y and z as the previous axis finishes.
    assign div_num = (r_state == S_FETCH) ? r_rx : ((r_axis == 2'd0) ? r_ry : r_rz);
    assign div_start = (r_state == S_FETCH && r_rw != '0)
                    || (div_done && r_axis != 2'd2 && r_state == S_DIV);

    lwc_divider #(.NB(XB), .DB(WB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(r_rw), .o_done(div_done), .o_quot(div_q)
    );

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
        r_px <= PB'(it_x) * PB'(it_w);
        r_py <= PB'(it_y) * PB'(it_w);
        r_pz <= PB'(it_z) * PB'(it_w);
        if (r_state == S_ADD || r_state == S_SCAN || r_state == S_CLEAR) begin
            r_rx <= r_mx[r_state == S_ADD ? it_label[AB-1:0] : r_idx];
            r_ry <= r_my[r_state == S_ADD ? it_label[AB-1:0] : r_idx];
            r_rz <= r_mz[r_state == S_ADD ? it_label[AB-1:0] : r_idx];
            r_rw <= r_mw[r_state == S_ADD ? it_label[AB-1:0] : r_idx];
        end
        if (r_state == S_READ && r_busy_hold && in_range) begin
            r_mx[it_label[AB-1:0]] <= r_rx + XB'(r_px);
            r_my[it_label[AB-1:0]] <= r_ry + XB'(r_py);
            r_mz[it_label[AB-1:0]] <= r_rz + XB'(r_pz);
            r_mw[it_label[AB-1:0]] <= r_rw + WB'(it_w);
        end
        if (r_state == S_CLEAR) begin
            r_mx[r_idx] <= '0;
            r_my[r_idx] <= '0;
            r_mz[r_idx] <= '0;
            r_mw[r_idx] <= '0;
        end
        if (div_done && r_state == S_DIV) begin
            unique case (r_axis)
                2'd0: o_cx <= div_q[COORD_BITS-1:0];
                2'd1: o_cy <= div_q[COORD_BITS-1:0];
                default: o_cz <= div_q[COORD_BITS-1:0];
            endcase
        end
        if (r_state == S_FETCH && r_rw == '0) begin
            o_cx <= '0;
            o_cy <= '0;
            o_cz <= '0;
        end
    end

    assign o_label = LB'(r_idx);
    assign o_last = (r_idx == AB'(LABELS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx <= '0;
            r_axis <= '0;
            r_busy_hold <= 1'b0;
            o_valid <= 1'b0;
            o_present <= 1'b0;
        end else begin
            unique case (r_state)
                S_READ: begin
                    if (r_busy_hold) begin
                        r_busy_hold <= 1'b0;
                        if (it_fin) begin
                            r_idx <= AB'(1);
                            r_state <= S_SCAN;
                        end
                    end else if (take) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_busy_hold <= 1'b1;
                    r_state <= S_READ;
                end
                S_SCAN: r_state <= S_FETCH;
                S_FETCH: begin
                    r_axis <= '0;
                    o_present <= (r_rw != '0);
                    if (r_rw == '0) begin
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_axis == 2'd2) begin
                            o_valid <= 1'b1;
                            r_state <= S_OUT;
                        end
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        if (o_last) begin
                            r_idx <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_CLEAR: begin
                    if (r_idx == AB'(LABELS - 1)) begin
                        r_idx <= '0;
                        r_state <= S_READ;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/labelled_weighted_centroid_unit.sv @@
// Channel   Dir  Contents
// s_axis    in   tdata: label, pos_x, pos_y, pos_z, weight; tlast: final_voxel
// m_axis    out  tdata: region_label, centroid_x, centroid_y, centroid_z; tuser: present
//                tlast: last_result
// Each voxel is read, added and written back before the next voxel is accepted.
// After the final voxel each label from 1 with nonzero weight uses the shared divider.
// After reset and after each image a clearing pass zeroes the sums of every label.
// A four-entry queue lets voxels be accepted while the back end is busy.
`default_nettype none
`include "labelled_weighted_centroid_unit_defines.svh"
module labelled_weighted_centroid_unit #(
    parameter int LABELS = lwc_pkg::LABELS_DEF,
    parameter int COORD_BITS = lwc_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_BITS = lwc_pkg::WEIGHT_BITS_DEF,
    parameter int IDW = ((lwc_pkg::LABEL_BITS + 3 * COORD_BITS + WEIGHT_BITS + 7) / 8) * 8,
    parameter int ODW = ((lwc_pkg::LABEL_BITS + 3 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // label, pos_x, pos_y, pos_z, weight from the lowest bit up
    input  wire logic [IDW-1:0] s_axis_tdata,
    input  wire logic           s_axis_tlast,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // region_label, centroid_x, centroid_y, centroid_z from the lowest bit up
    output logic [ODW-1:0]      m_axis_tdata,
    // present
    output logic                m_axis_tuser,
    output logic                m_axis_tlast
);
    localparam int LB = lwc_pkg::LABEL_BITS;
    localparam int FW = LB + 3 * COORD_BITS + WEIGHT_BITS;
    localparam int QW = FW + 1;

    logic          q_valid, q_ready;
    logic [QW-1:0] q_item;
    lwc_pkg::t_queue_status q_status;
    logic [LB-1:0] lab;
    logic [COORD_BITS-1:0] cx, cy, cz;

    lwc_front #(.COORD_BITS(COORD_BITS), .WEIGHT_BITS(WEIGHT_BITS), .QW(QW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item({s_axis_tlast, s_axis_tdata[FW-1:0]}),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item), .o_status(q_status)
    );

    lwc_back #(.LABELS(LABELS), .COORD_BITS(COORD_BITS), .WEIGHT_BITS(WEIGHT_BITS),
               .QW(QW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_label(lab), .o_cx(cx), .o_cy(cy), .o_cz(cz),
        .o_present(m_axis_tuser), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = ODW'({cz, cy, cx, lab});

    `LWC_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, q_status.full, !s_axis_tready, "full queue accepted")
    `LWC_ASSERT_IMPL(a_empty_idle, i_clk, i_rst_n, q_status.empty, !q_valid, "empty queue valid")
    `LWC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule
`default_nettype wire

@@ tb/lwc_centroid_checker.sv @@
`timescale 1ns / 1ps
module lwc_centroid_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [55:0] i_s_tdata,
    input  wire logic        i_s_tlast,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [39:0] i_m_tdata,
    input  wire logic        i_m_tuser,
    input  wire logic        i_m_tlast,
    output int               o_fails,
    output int               o_pending,
    output int               o_voxels,
    output int               o_results,
    output int               o_present
);
    typedef struct packed {
        logic [5:0] region;
        logic [9:0] cx;
        logic [9:0] cy;
        logic [9:0] cz;
        logic       present;
        logic       last;
    } t_centroid;

    localparam int NUM_LABELS = lwc_pkg::LABELS_DEF;

    logic [lwc_pkg::SUM_XYZ_BITS-1:0] acc_wx [NUM_LABELS];
    logic [lwc_pkg::SUM_XYZ_BITS-1:0] acc_wy [NUM_LABELS];
    logic [lwc_pkg::SUM_XYZ_BITS-1:0] acc_wz [NUM_LABELS];
    logic [lwc_pkg::SUM_W_BITS-1:0]   acc_w  [NUM_LABELS];
    t_centroid expected_centroids [$];

    initial begin
        o_fails = 0;
        o_voxels = 0;
        o_results = 0;
        o_present = 0;
    end

    assign o_pending = expected_centroids.size();

    task automatic report(input string field, input int want, input int got);
        $display("centroid %0d: %s expected %0d, got %0d", o_results, field, want, got);
        o_fails++;
    endtask

    task automatic clear_sums();
        for (int i = 0; i < NUM_LABELS; i++) begin
            acc_wx[i] = '0;
            acc_wy[i] = '0;
            acc_wz[i] = '0;
            acc_w[i] = '0;
        end
    endtask

    task automatic accumulate_voxel(input logic [55:0] data, input logic fin);
        logic [5:0]  lab;
        logic [55:0] w;
        t_centroid   c;
        lab = data[5:0];
        w = 56'(data[51:36]);
        acc_wx[lab] = acc_wx[lab] + 56'(data[15:6]) * w;
        acc_wy[lab] = acc_wy[lab] + 56'(data[25:16]) * w;
        acc_wz[lab] = acc_wz[lab] + 56'(data[35:26]) * w;
        acc_w[lab] = acc_w[lab] + w[45:0];
        if (fin) begin
            for (int i = 1; i < NUM_LABELS; i++) begin
                c = '0;
                c.region = 6'(i);
                c.last = (i == NUM_LABELS - 1);
                if (acc_w[i] != 0) begin
                    c.cx = 10'(acc_wx[i] / 56'(acc_w[i]));
                    c.cy = 10'(acc_wy[i] / 56'(acc_w[i]));
                    c.cz = 10'(acc_wz[i] / 56'(acc_w[i]));
                    c.present = 1'b1;
                end
                expected_centroids.push_back(c);
            end
            clear_sums();
        end
    endtask

    always @(posedge i_clk) begin
        t_centroid want;
        if (!i_rst_n) begin
            clear_sums();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                accumulate_voxel(i_s_tdata, i_s_tlast);
                o_voxels++;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_centroids.size() == 0) begin
                    report("unexpected item, region_label", 0, int'(i_m_tdata[5:0]));
                end else begin
                    want = expected_centroids.pop_front();
                    if (i_m_tdata[5:0] != want.region)
                        report("region_label", int'(want.region), int'(i_m_tdata[5:0]));
                    if (i_m_tdata[15:6] != want.cx)
                        report("centroid_x", int'(want.cx), int'(i_m_tdata[15:6]));
                    if (i_m_tdata[25:16] != want.cy)
                        report("centroid_y", int'(want.cy), int'(i_m_tdata[25:16]));
                    if (i_m_tdata[35:26] != want.cz)
                        report("centroid_z", int'(want.cz), int'(i_m_tdata[35:26]));
                    if (i_m_tuser != want.present)
                        report("present", int'(want.present), int'(i_m_tuser));
                    if (i_m_tlast != want.last)
                        report("last_result", int'(want.last), int'(i_m_tlast));
                    if (want.present)
                        o_present++;
                end
                o_results++;
            end
        end
    end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;
    localparam int RANDOM_VOXELS = 460;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fails, pending, voxels, results, present;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    int sent = 0;
    int images = 0;
    bit hold_req = 0;
    bit hold = 0;

    labelled_weighted_centroid_unit i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    lwc_centroid_checker i_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata),
        .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .i_m_tuser(m_axis_tuser),
        .i_m_tlast(m_axis_tlast),
        .o_fails(fails),
        .o_pending(pending),
        .o_voxels(voxels),
        .o_results(results),
        .o_present(present)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !hold && ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        wait (hold_req);
        @(negedge i_clk);
        hold = 1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold = 0;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("labelled_weighted_centroid_unit: mismatch");
            $finish;
        end
    end

    task automatic send_voxel(input logic [5:0] lab, input logic [9:0] px,
                              input logic [9:0] py, input logic [9:0] pz,
                              input logic [15:0] w, input logic fin);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, w, pz, py, px, lab};
        s_axis_tlast <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        if (fin)
            images++;
    endtask

    function automatic logic [9:0] rand_coord();
        case ($urandom_range(7))
            0: return 10'd0;
            1: return 10'd1023;
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_image(input int n);
        logic [5:0] base;
        int span;
        base = 6'($urandom);
        span = $urandom_range(1) ? 64 : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_voxel(6'((base + $urandom_range(span - 1)) % 64), rand_coord(), rand_coord(),
                       rand_coord(), rand_weight(), i == n - 1);
    endtask

    initial begin
        int n;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_voxel(6'd0, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 1'b0);
        send_voxel(6'd63, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 1'b0);
        send_voxel(6'd63, 10'd0, 10'd0, 10'd0, 16'hFFFF, 1'b0);
        send_voxel(6'd1, 10'd500, 10'd20, 10'd7, 16'd0, 1'b0);
        send_voxel(6'd5, 10'd0, 10'd0, 10'd0, 16'd1, 1'b0);
        send_voxel(6'd9, 10'd3, 10'd5, 10'd7, 16'd1, 1'b0);
        send_voxel(6'd9, 10'd4, 10'd6, 10'd9, 16'd2, 1'b0);
        send_voxel(6'd42, 10'h2AA, 10'h155, 10'h3FF, 16'hAAAA, 1'b0);
        send_voxel(6'd42, 10'h155, 10'h2AA, 10'h000, 16'h5555, 1'b1);
        send_voxel(6'd21, 10'd1, 10'd2, 10'd3, 16'h0100, 1'b1);
        send_voxel(6'd0, 10'd100, 10'd100, 10'd100, 16'd50, 1'b1);
        for (int i = 0; i < 6; i++)
            send_voxel(6'd33, 10'd1023, 10'd1022, 10'd1, 16'hFFFF, 1'b0);
        send_voxel(6'd33, 10'd0, 10'd0, 10'd0, 16'd0, 1'b1);

        sent = 0;
        while (sent < RANDOM_VOXELS) begin
            if (sent < RANDOM_VOXELS / 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 82;
            end else if (sent < 2 * RANDOM_VOXELS / 3) begin
                send_idle_pct = 82;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!hold_req && images > 0)
                    hold_req = 1;
            end
            n = $urandom_range(1, 40);
            send_image(n);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("%0d voxels in %0d images, %0d centroid items, %0d with nonzero weight",
                 voxels, images, results, present);
        $display("sender and receiver stalls swapped across phases, one long output hold");
        if (fails == 0)
            $display("labelled_weighted_centroid_unit: match");
        else
            $display("labelled_weighted_centroid_unit: mismatch");
        $finish;
    end
endmodule
